// ===== hdl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/mvm_pkg.sv =====
// types and constants of the matrix-vector multiply block
`default_nettype none

package mvm_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int IDX_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int LEN_W       = 9;
    localparam int CNT_W       = $clog2(MAX_COLUMNS + 1);
    localparam int EFF_W       = (LEN_W > CNT_W) ? LEN_W : CNT_W;
    localparam int DATA_W      = 32;
    localparam int ROW_W       = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_MATRIX = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic signed [DATA_W-1:0] value;
    } mvm_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] row_result;
        logic [ROW_W-1:0]         row_number;
    } mvm_out_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] vec;
        logic              last;
        logic [ROW_W-1:0]  row;
    } mvm_entry_t;

    typedef struct packed {
        logic       valid;
        mvm_entry_t entry;
    } mvm_push_t;

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } mvm_q_status_t;

endpackage

`default_nettype wire

// ===== hdl/mvm_front.sv =====
// front end: config register, vector store, column tracking, queue push
`default_nettype none

module mvm_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire mvm_pkg::mvm_in_t           in_word,
    input  wire logic                       cfg_write,
    input  wire logic [mvm_pkg::LEN_W-1:0]  cfg_data,
    input  wire mvm_pkg::mvm_q_status_t     q_status,
    output mvm_pkg::mvm_push_t              push
);

    logic [mvm_pkg::LEN_W-1:0]  row_length_reg;
    logic [mvm_pkg::IDX_W-1:0]  load_idx_reg, load_idx_next;
    logic [mvm_pkg::IDX_W-1:0]  col_idx_reg, col_idx_next;
    logic [mvm_pkg::ROW_W-1:0]  row_cnt_reg, row_cnt_next;
    logic                       s1_valid_reg;
    logic [mvm_pkg::DATA_W-1:0] s1_value_reg;
    logic                       s1_last_reg;
    logic [mvm_pkg::ROW_W-1:0]  s1_row_reg;
    logic [mvm_pkg::DATA_W-1:0] vec_rd_reg;
    logic [mvm_pkg::DATA_W-1:0] vec_mem [mvm_pkg::MAX_COLUMNS];

    logic [mvm_pkg::EFF_W-1:0]  eff_len;
    logic [mvm_pkg::EFF_W-1:0]  load_step, col_step;
    logic                       load_wrap, col_wrap;
    logic [mvm_pkg::QCNT_W:0]   occupancy;
    logic                       accept, is_load, is_matrix;

    // clamp row length into 1..MAX_COLUMNS
    always_comb
    begin
        eff_len = mvm_pkg::EFF_W'(row_length_reg);
        if (eff_len == '0)
        begin
            eff_len = mvm_pkg::EFF_W'(1);
        end
        else if (eff_len > mvm_pkg::EFF_W'(mvm_pkg::MAX_COLUMNS))
        begin
            eff_len = mvm_pkg::EFF_W'(mvm_pkg::MAX_COLUMNS);
        end
    end

    // stall on queue entries plus the one in the stage register
    assign occupancy = (mvm_pkg::QCNT_W + 1)'(q_status.count)
                     + (mvm_pkg::QCNT_W + 1)'(s1_valid_reg);
    assign in_stall  = occupancy >= (mvm_pkg::QCNT_W + 1)'(mvm_pkg::QUEUE_DEPTH);

    assign accept    = in_valid && !in_stall;
    assign is_load   = accept && (in_word.operation == mvm_pkg::OP_LOAD);
    assign is_matrix = accept && (in_word.operation == mvm_pkg::OP_MATRIX);

    assign load_step = mvm_pkg::EFF_W'(load_idx_reg) + mvm_pkg::EFF_W'(1);
    assign col_step  = mvm_pkg::EFF_W'(col_idx_reg) + mvm_pkg::EFF_W'(1);
    assign load_wrap = load_step >= eff_len;
    assign col_wrap  = col_step >= eff_len;

    always_comb
    begin
        load_idx_next = load_idx_reg;
        col_idx_next  = col_idx_reg;
        row_cnt_next  = row_cnt_reg;
        if (is_load)
        begin
            load_idx_next = load_wrap ? '0 : load_step[mvm_pkg::IDX_W-1:0];
        end
        if (is_matrix)
        begin
            col_idx_next = col_wrap ? '0 : col_step[mvm_pkg::IDX_W-1:0];
            if (col_wrap)
            begin
                row_cnt_next = row_cnt_reg + mvm_pkg::ROW_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= mvm_pkg::LEN_W'(1);
            load_idx_reg   <= '0;
            col_idx_reg    <= '0;
            row_cnt_reg    <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                row_length_reg <= cfg_data;
            end
            load_idx_reg <= load_idx_next;
            col_idx_reg  <= col_idx_next;
            row_cnt_reg  <= row_cnt_next;
            s1_valid_reg <= is_matrix;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_matrix)
        begin
            s1_value_reg <= in_word.value;
            s1_last_reg  <= col_wrap;
            s1_row_reg   <= row_cnt_reg;
        end
    end

    // vector store, registered read
    always_ff @(posedge clk)
    begin
        if (is_load)
        begin
            vec_mem[load_idx_reg] <= in_word.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_matrix)
        begin
            vec_rd_reg <= vec_mem[col_idx_reg];
        end
    end

    assign push.valid       = s1_valid_reg;
    assign push.entry.value = s1_value_reg;
    assign push.entry.vec   = vec_rd_reg;
    assign push.entry.last  = s1_last_reg;
    assign push.entry.row   = s1_row_reg;

endmodule

`default_nettype wire

// ===== hdl/mvm_queue.sv =====
// short queue between front and back
`default_nettype none

module mvm_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire mvm_pkg::mvm_push_t     push,
    input  wire logic                   pop,
    output mvm_pkg::mvm_entry_t         head,
    output mvm_pkg::mvm_q_status_t      status
);

    mvm_pkg::mvm_entry_t         entries [mvm_pkg::QUEUE_DEPTH];
    logic [mvm_pkg::QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [mvm_pkg::QCNT_W-1:0]  count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !pop)
        begin
            count_next = count_reg + mvm_pkg::QCNT_W'(1);
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - mvm_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= (wr_ptr_reg == mvm_pkg::QPTR_W'(mvm_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + mvm_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == mvm_pkg::QPTR_W'(mvm_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + mvm_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entries[wr_ptr_reg] <= push.entry;
        end
    end

    assign head         = entries[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

endmodule

`default_nettype wire

// ===== hdl/mvm_back.sv =====
// back end: multiply, accumulate, output register
`default_nettype none

module mvm_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire mvm_pkg::mvm_entry_t    head,
    input  wire mvm_pkg::mvm_q_status_t q_status,
    output logic                        pop,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output mvm_pkg::mvm_out_t           out_word
);

    logic                       mul_valid_reg, mul_valid_next;
    logic [mvm_pkg::DATA_W-1:0] prod_reg;
    logic                       mul_last_reg;
    logic [mvm_pkg::ROW_W-1:0]  mul_row_reg;
    logic [mvm_pkg::DATA_W-1:0] sum_reg, sum_next;
    logic [mvm_pkg::DATA_W-1:0] acc;
    logic                       out_valid_reg, out_valid_next;
    mvm_pkg::mvm_out_t          out_word_reg;
    logic                       mul_advance, finish;

    // a finished row waits only for a free output register
    assign mul_advance = !mul_valid_reg || !mul_last_reg || !out_valid_reg || !out_stall;
    assign pop         = !q_status.empty && mul_advance;
    assign finish      = mul_valid_reg && mul_last_reg && mul_advance;
    assign acc         = sum_reg + prod_reg;

    always_comb
    begin
        mul_valid_next = mul_valid_reg;
        if (pop)
        begin
            mul_valid_next = 1'b1;
        end
        else if (mul_advance)
        begin
            mul_valid_next = 1'b0;
        end

        sum_next = sum_reg;
        if (mul_valid_reg && mul_advance)
        begin
            sum_next = mul_last_reg ? '0 : acc;
        end

        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= mul_valid_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            prod_reg     <= mvm_pkg::DATA_W'(head.value * head.vec);
            mul_last_reg <= head.last;
            mul_row_reg  <= head.row;
        end
        if (finish)
        begin
            out_word_reg.row_result <= acc;
            out_word_reg.row_number <= mul_row_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire

// ===== hdl/matrix_vector_multiply.sv =====
// top level of the streamed integer matrix-vector multiply
// a row's last matrix word passes the front stage register, the queue, the product register and the output register
// throughput: one input word per cycle while in_stall is low, vector loads and matrix words alike
// the rate is set by the single multiply-accumulate unit in the back end
// rst_n is asynchronous, active low: counters, sum, queue cleared, row length set to 1
// vector store is not cleared and holds unknown data until loaded
`default_nettype none
`include "assert_macros.svh"

module matrix_vector_multiply (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire mvm_pkg::mvm_in_t           in_word,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output mvm_pkg::mvm_out_t               out_word,
    input  wire logic                       cfg_write,
    input  wire logic [mvm_pkg::LEN_W-1:0]  cfg_data
);

    // front to queue: one entry per matrix word, carrying its vector element
    mvm_pkg::mvm_push_t     push;
    // queue to back: head entry and fill level
    mvm_pkg::mvm_entry_t    head;
    mvm_pkg::mvm_q_status_t q_status;
    logic                   pop;

    // front: row length register, load and column counters, vector store read
    mvm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .push      (push)
    );

    // decouples the front from output stalls
    mvm_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .status (q_status)
    );

    // back: registered multiply, then accumulate into the row sum and output word
    mvm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    // the front must never push into a full queue
    `ASSERT_IMPLIES(a_no_overflow, push.valid,
        q_status.count < mvm_pkg::QCNT_W'(mvm_pkg::QUEUE_DEPTH))
    // the back must never pop an empty queue
    `ASSERT_IMPLIES(a_no_underflow, pop, !q_status.empty)
    // every accepted matrix word reaches the queue in the next cycle
    `ASSERT_NEXT(a_matrix_pushed,
        in_valid && !in_stall && (in_word.operation == mvm_pkg::OP_MATRIX), push.valid)

endmodule

`default_nettype wire
